>>> rtl/hrfb_pkg.sv
package hrfb_pkg;

  // Item and result words
  typedef struct packed {
    logic        mode;
    logic [15:0] command;
    logic [7:0]  length;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_word_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PREAMBLE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 2'd1;

  // Item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // Frame constants
  localparam logic [7:0] BYTE_PREAMBLE = 8'hFF;
  localparam logic [7:0] BYTE_DELIM    = 8'h82;
  localparam logic [7:0] BYTE_EXPAND   = 8'h1F;
  localparam logic [4:0] PREAMBLE_MAX  = 5'd20;
  localparam logic [4:0] PREAMBLE_RST  = 5'd5;
  localparam logic [2:0] ADDR_LAST     = 3'd4;

  // Microprogram addresses
  localparam int unsigned PcW = 4;
  localparam logic [PcW-1:0] PC_PRE_TEST = 4'd0;
  localparam logic [PcW-1:0] PC_PRE      = 4'd1;
  localparam logic [PcW-1:0] PC_DELIM    = 4'd2;
  localparam logic [PcW-1:0] PC_ADDR     = 4'd3;
  localparam logic [PcW-1:0] PC_CMD_SEL  = 4'd4;
  localparam logic [PcW-1:0] PC_EXPAND   = 4'd5;
  localparam logic [PcW-1:0] PC_LEN2     = 4'd6;
  localparam logic [PcW-1:0] PC_CMD_HI   = 4'd7;
  localparam logic [PcW-1:0] PC_CMD_LO_X = 4'd8;
  localparam logic [PcW-1:0] PC_CMD_LO   = 4'd9;
  localparam logic [PcW-1:0] PC_LEN      = 4'd10;
  localparam logic [PcW-1:0] PC_FIN      = 4'd11;
  localparam logic [PcW-1:0] PC_DATA     = 4'd12;
  localparam logic [PcW-1:0] PC_CSUM     = 4'd13;

  typedef enum logic [3:0] {
    SRC_PREAMBLE,
    SRC_DELIM,
    SRC_ADDR,
    SRC_EXPAND,
    SRC_LEN2,
    SRC_CMD_HI,
    SRC_CMD_LO,
    SRC_LEN,
    SRC_DATA,
    SRC_CSUM
  } src_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_PRE_DONE,
    COND_ADDR_MORE,
    COND_CMD_SHORT,
    COND_LEN_ZERO,
    COND_LEFT_MORE
  } cond_e;

  typedef struct packed {
    logic           emit;
    src_e           src;
    logic           xor_en;
    logic           cnt_clr;
    logic           cnt_inc;
    logic           left_dec;
    logic           close;
    logic           fin;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  function automatic ucode_t mk(logic emit, src_e src, logic xor_en, logic cnt_clr,
                                logic cnt_inc, logic left_dec, logic close, logic fin,
                                cond_e cond, logic [PcW-1:0] target);
    ucode_t w;
    w.emit     = emit;
    w.src      = src;
    w.xor_en   = xor_en;
    w.cnt_clr  = cnt_clr;
    w.cnt_inc  = cnt_inc;
    w.left_dec = left_dec;
    w.close    = close;
    w.fin      = fin;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // Control store: one word per step, a taken condition jumps to target
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      PC_PRE_TEST: w = mk(1'b0, SRC_PREAMBLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_PRE_DONE, PC_DELIM);
      PC_PRE:      w = mk(1'b1, SRC_PREAMBLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                          COND_ALWAYS, PC_PRE_TEST);
      PC_DELIM:    w = mk(1'b1, SRC_DELIM, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_DELIM);
      PC_ADDR:     w = mk(1'b1, SRC_ADDR, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                          COND_ADDR_MORE, PC_ADDR);
      PC_CMD_SEL:  w = mk(1'b0, SRC_CMD_LO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_CMD_SHORT, PC_CMD_LO);
      PC_EXPAND:   w = mk(1'b1, SRC_EXPAND, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_EXPAND);
      PC_LEN2:     w = mk(1'b1, SRC_LEN2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_LEN2);
      PC_CMD_HI:   w = mk(1'b1, SRC_CMD_HI, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_CMD_HI);
      PC_CMD_LO_X: w = mk(1'b1, SRC_CMD_LO, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_ALWAYS, PC_FIN);
      PC_CMD_LO:   w = mk(1'b1, SRC_CMD_LO, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_CMD_LO);
      PC_LEN:      w = mk(1'b1, SRC_LEN, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_NEVER, PC_LEN);
      PC_FIN:      w = mk(1'b0, SRC_LEN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          COND_LEN_ZERO, PC_CSUM);
      PC_DATA:     w = mk(1'b1, SRC_DATA, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                          COND_LEFT_MORE, PC_FIN);
      PC_CSUM:     w = mk(1'b1, SRC_CSUM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                          COND_NEVER, PC_CSUM);
      default:     w = mk(1'b0, SRC_CSUM, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                          COND_NEVER, PC_PRE_TEST);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/hart_request_frame_builder.sv
// Channel | Dir | Handshake                | Word
// --------+-----+--------------------------+--------------------------------------
// in      | in  | in_valid_i / in_stall_o  | hrfb_pkg::in_word_t (mode, command..)
// out     | out | out_valid_o / out_stall_i| hrfb_pkg::out_word_t (byte, frame_end)
// cfg     | in  | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i (40 bits)
//
// Start word: accept, then a test and an emitting step per preamble and a closing test,
// delimiter, five address bytes, form select, 2 header bytes short or 4 expanded, a finish
// test, and the checksum when the length is zero. Data word: accept, emit, then a finish
// test or the checksum; a data word with no frame open is accepted and dropped.
// Emitting steps wait while the output word is unaccepted; reset (rst_ni low, asynchronous)
// closes any frame and restores the configuration and sequencer registers.
module hart_request_frame_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hrfb_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hrfb_pkg::out_word_t           out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hrfb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [39:0]                   cfg_data_i
);

  // Configuration registers
  logic [4:0]  pre_cnt_q;
  logic [39:0] dev_addr_q;

  // Sequencer state
  logic                     busy_q;
  logic [hrfb_pkg::PcW-1:0] pc_q, pc_d;
  logic [4:0]               cnt_q;

  // Frame state
  logic        frame_open_q;
  logic [7:0]  xor_q;
  logic [7:0]  left_q;

  // Latched item fields
  logic [15:0] cmd_q;
  logic [7:0]  len_q;
  logic [7:0]  data_q;

  // Output register
  logic                 out_valid_q;
  hrfb_pkg::out_word_t  out_word_q;

  hrfb_pkg::ucode_t uw;
  logic             in_acc;
  logic             out_free;
  logic             go;
  logic             taken;
  logic [4:0]       pre_sat;
  logic [7:0]       addr_byte;
  logic [7:0]       emit_byte;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i && !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Fetch the control word for this step; stall on emit until the output frees up
  assign uw = hrfb_pkg::ucode_rom(pc_q);
  assign go = busy_q && (!uw.emit || out_free);

  // Clamp the preamble count at its maximum
  assign pre_sat = (pre_cnt_q > hrfb_pkg::PREAMBLE_MAX) ? hrfb_pkg::PREAMBLE_MAX : pre_cnt_q;

  // Address goes out most significant byte first
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    addr_byte = dev_addr_q[39:32];
      3'd1:    addr_byte = dev_addr_q[31:24];
      3'd2:    addr_byte = dev_addr_q[23:16];
      3'd3:    addr_byte = dev_addr_q[15:8];
      3'd4:    addr_byte = dev_addr_q[7:0];
      default: addr_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (uw.src)
      hrfb_pkg::SRC_PREAMBLE: emit_byte = hrfb_pkg::BYTE_PREAMBLE;
      hrfb_pkg::SRC_DELIM:    emit_byte = hrfb_pkg::BYTE_DELIM;
      hrfb_pkg::SRC_ADDR:     emit_byte = addr_byte;
      hrfb_pkg::SRC_EXPAND:   emit_byte = hrfb_pkg::BYTE_EXPAND;
      hrfb_pkg::SRC_LEN2:     emit_byte = len_q + 8'd2;
      hrfb_pkg::SRC_CMD_HI:   emit_byte = cmd_q[15:8];
      hrfb_pkg::SRC_CMD_LO:   emit_byte = cmd_q[7:0];
      hrfb_pkg::SRC_LEN:      emit_byte = len_q;
      hrfb_pkg::SRC_DATA:     emit_byte = data_q;
      hrfb_pkg::SRC_CSUM:     emit_byte = xor_q;
      default:                emit_byte = 8'h00;
    endcase
  end

  // Jump condition
  always_comb begin
    case (uw.cond)
      hrfb_pkg::COND_NEVER:     taken = 1'b0;
      hrfb_pkg::COND_ALWAYS:    taken = 1'b1;
      hrfb_pkg::COND_PRE_DONE:  taken = (cnt_q == pre_sat);
      hrfb_pkg::COND_ADDR_MORE: taken = (cnt_q[2:0] != hrfb_pkg::ADDR_LAST);
      hrfb_pkg::COND_CMD_SHORT: taken = (cmd_q[15:8] == 8'h00);
      hrfb_pkg::COND_LEN_ZERO:  taken = (len_q == 8'h00);
      hrfb_pkg::COND_LEFT_MORE: taken = (left_q != 8'd1);
      default:                  taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = taken ? uw.target : pc_q + 4'd1;
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= hrfb_pkg::PREAMBLE_RST;
      dev_addr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hrfb_pkg::CFG_PREAMBLE_COUNT: pre_cnt_q  <= cfg_data_i[4:0];
        hrfb_pkg::CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pc_q         <= hrfb_pkg::PC_PRE_TEST;
      cnt_q        <= '0;
      frame_open_q <= 1'b0;
      xor_q        <= '0;
      left_q       <= '0;
    end else if (in_acc) begin
      if (in_word_i.mode == hrfb_pkg::MODE_START) begin
        // Open a new frame, dropping any open one
        busy_q       <= 1'b1;
        pc_q         <= hrfb_pkg::PC_PRE_TEST;
        cnt_q        <= '0;
        frame_open_q <= 1'b1;
        xor_q        <= '0;
        left_q       <= in_word_i.length;
      end else if (frame_open_q) begin
        busy_q <= 1'b1;
        pc_q   <= hrfb_pkg::PC_DATA;
      end
    end else if (go) begin
      pc_q <= pc_d;
      if (uw.fin) begin
        busy_q <= 1'b0;
      end
      if (uw.cnt_clr) begin
        cnt_q <= '0;
      end else if (uw.cnt_inc) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (uw.left_dec) begin
        left_q <= left_q - 8'd1;
      end
      if (uw.close) begin
        xor_q        <= '0;
        left_q       <= '0;
        frame_open_q <= 1'b0;
      end else if (uw.xor_en) begin
        xor_q <= xor_q ^ emit_byte;
      end
      // Finish a header or a data byte with data to follow
      if (pc_q == hrfb_pkg::PC_FIN && !taken) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Latch item fields on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_word_i.mode == hrfb_pkg::MODE_START) begin
        cmd_q <= in_word_i.command;
        len_q <= in_word_i.length;
      end
      data_q <= in_word_i.data_byte;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && uw.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && uw.emit) begin
      out_word_q.out_byte  <= emit_byte;
      out_word_q.frame_end <= uw.close;
    end
  end

  // A start word always enters the program at the preamble test
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.mode == hrfb_pkg::MODE_START
      |=> busy_q && pc_q == hrfb_pkg::PC_PRE_TEST)
    else $error("start word did not enter the program at the preamble test");

  // An idle open frame always expects more data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q && !busy_q |-> left_q != 8'h00)
    else $error("open frame idle with no data left");

  // The program counter never leaves the control store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q <= hrfb_pkg::PC_CSUM)
    else $error("program counter out of range");

  // An emitting step never overwrites an unaccepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && uw.emit |-> !(out_valid_q && out_stall_i))
    else $error("output word overwritten while stalled");

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrfb_pkg::*;

  // Largest command that still fits the short header form
  localparam logic [15:0] CMD_SHORT_MAX = 16'd255;
  // Random stimulus size, counted in words that the builder acts on
  localparam int unsigned RANDOM_WORDS = 200;
  // Idle time before a register write, so an ignored data word can finish
  localparam int unsigned SETTLE_CYCLES = 8;
  // Tail after the last byte: one full header at the largest preamble count and more
  localparam int unsigned DRAIN_CYCLES = 64;
  // Watchdog, several times the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned MAX_PRINTED = 40;

  // Directed plan: a word for the builder, or a register write
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_PRE,
    ROW_ADDR
  } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        mode;
    logic [15:0] command;
    logic [7:0]  length;
    logic [7:0]  data_byte;
    logic [39:0] value;
    bit          typed;
    int unsigned want_n;
    logic [7:0]  want_byte;
    logic        want_end;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 24;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1ns clk_i = ~clk_i;

  // Everything the bench drives starts at a known value
  logic                 in_valid_i  = 1'b0;
  in_word_t             in_word_i   = '0;
  logic                 out_stall_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [39:0]          cfg_data_i  = '0;

  logic                 in_stall_o;
  logic                 out_valid_o;
  out_word_t            out_word_o;
  logic                 cfg_ready_o;

  hart_request_frame_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor: its own copy of the registers and of the frame state.
  // Every byte the builder should send is queued here in transmit order.
  // ---------------------------------------------------------------------------
  logic [4:0]  preamble_reg = PREAMBLE_RST;
  logic [39:0] address_reg  = '0;
  logic [7:0]  frame_xor    = '0;
  logic [7:0]  bytes_to_go  = '0;
  logic        frame_live   = 1'b0;

  out_word_t   pending_bytes[$];
  int unsigned burst_len;     // bytes caused by the latest accepted word
  out_word_t   burst_tail;    // last of those bytes

  int unsigned mismatch_count = 0;
  int unsigned bytes_checked  = 0;
  int unsigned frames_closed  = 0;
  int unsigned words_sent     = 0;
  int unsigned words_used     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned cycle_count    = 0;

  // Stall and gap ceilings; dropped to zero now and then for back-to-back stretches
  int unsigned gap_cap   = 19;
  int unsigned stall_cap = 19;
  int unsigned next_gap  = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void emit_byte(input logic [7:0] b, input logic in_sum,
                                    input logic last);
    out_word_t o;
    o.out_byte  = b;
    o.frame_end = last;
    pending_bytes.push_back(o);
    if (in_sum) begin
      frame_xor ^= b;
    end
    burst_len++;
    burst_tail = o;
  endfunction

  function automatic void close_frame_bytes();
    emit_byte(frame_xor, 1'b0, 1'b1);
    frame_xor   = '0;
    bytes_to_go = '0;
    frame_live  = 1'b0;
  endfunction

  function automatic void predict_frame_bytes(input in_word_t w);
    logic [4:0] n_pre;
    burst_len = 0;
    if (w.mode == MODE_START) begin
      // A start drops any open frame: no checksum for it, sum restarts
      n_pre     = (preamble_reg > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_reg;
      frame_xor = '0;
      repeat (n_pre) emit_byte(BYTE_PREAMBLE, 1'b0, 1'b0);
      emit_byte(BYTE_DELIM, 1'b1, 1'b0);
      for (int k = ADDR_LAST; k >= 0; k--) begin
        emit_byte(address_reg[8*k +: 8], 1'b1, 1'b0);
      end
      if (w.command > CMD_SHORT_MAX) begin
        // Expanded form: byte count carries the two command bytes, wraps at 256
        emit_byte(BYTE_EXPAND, 1'b1, 1'b0);
        emit_byte(w.length + 8'd2, 1'b1, 1'b0);
        emit_byte(w.command[15:8], 1'b1, 1'b0);
        emit_byte(w.command[7:0], 1'b1, 1'b0);
      end else begin
        emit_byte(w.command[7:0], 1'b1, 1'b0);
        emit_byte(w.length, 1'b1, 1'b0);
      end
      bytes_to_go = w.length;
      frame_live  = 1'b1;
      if (bytes_to_go == 0) begin
        close_frame_bytes();
      end
    end else if (frame_live) begin
      emit_byte(w.data_byte, 1'b1, 1'b0);
      bytes_to_go = bytes_to_go - 8'd1;
      if (bytes_to_go == 0) begin
        close_frame_bytes();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, predict for an accepted input word first,
  // then check an accepted output word against the oldest expectation.
  // Both in one block, so a same-edge push and pop cannot race.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_frame_bytes(in_word_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                    out_word_o.out_byte));
        end else begin
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (out_word_o.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_word_o.out_byte, want.out_byte));
          end
          if (out_word_o.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b on byte %02h, expected %b",
                                      out_word_o.frame_end, out_word_o.out_byte,
                                      want.frame_end));
          end
          if (want.frame_end) begin
            frames_closed++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing byte ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               pending_bytes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: draw a stall for every byte, hold it, then release and wait
  // for the byte to go. Every 32 bytes re-pick the ceiling, sometimes zero.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = $urandom_range(0, stall_cap);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 32 == 0) begin
        stall_cap = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge. Wait the gap drawn last time, present
  // the word, hold it until taken, then draw the gap before the next word.
  // With no gap, valid stays high straight into the next word.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    repeat (next_gap) @(negedge clk_i);
    in_word_i  <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
    if (burst_len != 0) begin
      words_used++;
    end
    next_gap = $urandom_range(0, gap_cap);
    if (next_gap != 0) begin
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid if the last word left it high
  task automatic park_input();
    if (next_gap == 0) begin
      in_valid_i <= 1'b0;
    end
  endtask

  // Write a register only once the builder has gone quiet
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [39:0] value);
    park_input();
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_PREAMBLE_COUNT) begin
      preamble_reg = value[4:0];
    end else begin
      address_reg = value;
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_word_t data_word();
    in_word_t w;
    // Command and length are don't-care here; toggle them anyway
    w.mode      = MODE_DATA;
    w.command   = 16'($urandom);
    w.length    = 8'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t start_word(input logic [7:0] len);
    in_word_t w;
    w.mode      = MODE_START;
    w.length    = len;
    w.data_byte = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       w.command = 16'h0000;
      1:       w.command = CMD_SHORT_MAX;
      2:       w.command = CMD_SHORT_MAX + 16'd1;
      3:       w.command = 16'hFFFF;
      4, 5, 6: w.command = 16'($urandom_range(0, 255));
      default: w.command = 16'($urandom_range(256, 65535));
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t   plan [PLAN_LEN];
    in_word_t    w;
    int unsigned base;
    int unsigned roll;
    int unsigned n_data;
    int unsigned frame_no;
    logic [7:0]  len;
    bit          long_done;

    // Typed expectations: first frame after reset (5 preambles, address zero),
    // ignored data with no frame open, and the expanded header with no
    // preambles and an all-ones address. Everything else rests on the predictor.
    plan = '{
      '{ROW_ITEM, MODE_START, 16'h0000, 8'h00, 8'h00, 40'h0, 1'b1, 14, 8'h82, 1'b1},
      '{ROW_ITEM, MODE_DATA,  16'hFFFF, 8'hFF, 8'hFF, 40'h0, 1'b1, 0,  8'h00, 1'b0},
      '{ROW_ADDR, MODE_START, 16'h0000, 8'h00, 8'h00, 40'hFF_FFFF_FFFF, 1'b0, 0, 8'h00, 1'b0},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd0,  1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'hFFFF, 8'h00, 8'hFF, 40'h0, 1'b1, 11, 8'h60, 1'b1},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd31, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h00FF, 8'h02, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'hFF, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h0100, 8'hFF, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'h5A, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h0001, 8'h01, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'hA5, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd20, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ADDR, MODE_START, 16'h0000, 8'h00, 8'h00, 40'h12_3456_789A, 1'b0, 0, 8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h8000, 8'hFD, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'hAA, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h007F, 8'h00, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd21, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h0100, 8'hFE, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd4,  1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_START, 16'h0003, 8'h01, 8'h00, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_ITEM, MODE_DATA,  16'h0000, 8'h00, 8'h80, 40'h0, 1'b0, 0,  8'h00, 1'b0},
      '{ROW_PRE,  MODE_START, 16'h0000, 8'h00, 8'h00, 40'd5,  1'b0, 0,  8'h00, 1'b0}
    };

    // Hold reset, then release it on a falling edge
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed walk: saturation, zero preambles, wrap of the expanded count,
    // start over an open frame, stray data
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_PRE) begin
        write_register(CFG_PREAMBLE_COUNT, plan[r].value);
      end else if (plan[r].kind == ROW_ADDR) begin
        write_register(CFG_DEVICE_ADDRESS, plan[r].value);
      end else begin
        w.mode      = plan[r].mode;
        w.command   = plan[r].command;
        w.length    = plan[r].length;
        w.data_byte = plan[r].data_byte;
        send_word(w);
        if (plan[r].typed) begin
          if (burst_len != plan[r].want_n) begin
            report_mismatch($sformatf("plan row %0d predicts %0d bytes, table says %0d",
                                      r, burst_len, plan[r].want_n));
          end else if (burst_len != 0 && (burst_tail.out_byte !== plan[r].want_byte ||
                                          burst_tail.frame_end !== plan[r].want_end)) begin
            report_mismatch($sformatf("plan row %0d ends on %02h/%b, table says %02h/%b",
                                      r, burst_tail.out_byte, burst_tail.frame_end,
                                      plan[r].want_byte, plan[r].want_end));
          end
        end
      end
    end

    // Random part: mostly whole frames with random content, some cut short by
    // a new start, some stray data with no frame open. Re-program every ten
    // frames and re-pick the gap ceiling at the same time.
    base      = words_used;
    frame_no  = 0;
    long_done = 1'b0;
    while (words_used - base < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 3)) send_word(data_word());
      end else if (roll < 20) begin
        len    = 8'($urandom_range(1, 255));
        n_data = (len - 1 < 5) ? len - 1 : 5;
        send_word(start_word(len));
        repeat ($urandom_range(0, n_data)) send_word(data_word());
      end else begin
        if (!long_done && words_used - base >= RANDOM_WORDS / 2) begin
          // one long frame to walk the byte counter down from high values
          len       = 8'($urandom_range(100, 253));
          long_done = 1'b1;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = 8'($urandom_range(0, 3));
            6, 7, 8:          len = 8'($urandom_range(4, 12));
            default:          len = 8'($urandom_range(13, 30));
          endcase
        end
        send_word(start_word(len));
        repeat (len) send_word(data_word());
      end
      frame_no++;
      if (frame_no % 10 == 0) begin
        gap_cap = ($urandom_range(0, 2) == 0) ? 0 : 19;
        case ($urandom_range(0, 4))
          0:       write_register(CFG_PREAMBLE_COUNT, 40'd0);
          1:       write_register(CFG_PREAMBLE_COUNT, 40'd20);
          2:       write_register(CFG_PREAMBLE_COUNT, 40'd31);
          3:       write_register(CFG_PREAMBLE_COUNT, 40'd5);
          default: write_register(CFG_PREAMBLE_COUNT, 40'($urandom_range(0, 31)));
        endcase
        case ($urandom_range(0, 3))
          0:       write_register(CFG_DEVICE_ADDRESS, '0);
          1:       write_register(CFG_DEVICE_ADDRESS, '1);
          default: write_register(CFG_DEVICE_ADDRESS, {8'($urandom), 32'($urandom)});
        endcase
      end
    end

    // Drain: wait for every expected byte, then watch a while for strays
    park_input();
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d input words (%0d acted on), %0d bytes checked, %0d frames closed",
             words_sent, words_used, bytes_checked, frames_closed);
    $display("%0d register writes, %0d mismatches", cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hrfb_pkg.sv
rtl/hart_request_frame_builder.sv
bench/tb_top.sv
